@@ design/hbe_pkg.sv @@
// Shared types and constants for the histogram binning engine.
// Holds the register indexes, stream widths and the control bundles between modules.
// No dependencies.
package hbe_pkg;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_RANGE_MIN = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BINS_PER_UNIT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BIN_COUNT = 2'd2;

   localparam logic [31:0] RANGE_MIN_RESET = 32'd0;
   localparam logic [31:0] BINS_PER_UNIT_RESET = 32'd65536;
   localparam logic [8:0] BIN_COUNT_RESET = 9'd256;

   localparam int SAMPLE_W = 32;
   localparam int READ_BIN_W = 8;
   localparam int BIN_INDEX_W = 8;
   localparam int COUNT_W = 32;

   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 40;

   localparam logic MODE_ACCUMULATE = 1'b0;
   localparam logic MODE_READ_CLEAR = 1'b1;

   typedef struct packed {
      logic load;
      logic mult;
   } calc_ctl_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
      logic clear_op;
   } store_ctl_type;

endpackage

@@ design/hbe_bin_calc.sv @@
// Bin index datapath: range offset, reciprocal multiply and clamp to the bins in use.
// Depends on hbe_pkg for the control bundle and field widths.
module hbe_bin_calc #(
   parameter int MAX_BINS = 256
) (
   input  logic                             clock,
   input  hbe_pkg::calc_ctl_type            ctl,
   input  logic                             mode,
   input  logic [hbe_pkg::SAMPLE_W-1:0]     sample,
   input  logic [hbe_pkg::READ_BIN_W-1:0]   read_bin,
   input  logic [31:0]                      range_min,
   input  logic [31:0]                      bins_per_unit,
   input  logic [8:0]                       bin_count,
   output logic                             item_mode,
   output logic [$clog2(MAX_BINS)-1:0]      bin_addr,
   output logic [hbe_pkg::BIN_INDEX_W-1:0]  bin_index,
   output logic [$clog2(MAX_BINS)-1:0]      last_bin,
   output logic                             bin_clamped,
   output logic                             bin_hit
);

   localparam int ADDR_W = $clog2(MAX_BINS);
   localparam int NUSE_W = ADDR_W + 1;

   logic                           mode_ff;
   logic [hbe_pkg::READ_BIN_W-1:0] read_bin_ff;
   logic                           below_ff;
   logic [31:0]                    diff_ff;
   logic [31:0]                    prod_hi_ff;

   logic [32:0]       diff_wide;
   logic [63:0]       prod;
   logic [NUSE_W-1:0] nuse;
   logic [NUSE_W-1:0] nuse_last;
   logic              hi_over;

   assign diff_wide = {sample[31], sample} - {range_min[31], range_min};
   assign prod = 64'(diff_ff) * 64'(bins_per_unit);

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         mode_ff <= mode;
         read_bin_ff <= read_bin;
         below_ff <= diff_wide[32];
         diff_ff <= diff_wide[31:0];
      end
      if (ctl.mult) begin
         prod_hi_ff <= prod[63:32];
      end
   end

   always_comb begin
      if (bin_count == 9'd0) begin
         nuse = NUSE_W'(1);
      end else if (32'(bin_count) > MAX_BINS) begin
         nuse = NUSE_W'(MAX_BINS);
      end else begin
         nuse = NUSE_W'(bin_count);
      end
   end

   assign nuse_last = nuse - NUSE_W'(1);
   assign last_bin = nuse_last[ADDR_W-1:0];
   assign hi_over = prod_hi_ff >= 32'(nuse);

   always_comb begin
      if (mode_ff == hbe_pkg::MODE_READ_CLEAR) begin
         bin_addr = ADDR_W'(read_bin_ff);
      end else if (below_ff) begin
         bin_addr = '0;
      end else if (hi_over) begin
         bin_addr = last_bin;
      end else begin
         bin_addr = prod_hi_ff[ADDR_W-1:0];
      end
   end

   assign bin_index = (mode_ff == hbe_pkg::MODE_READ_CLEAR) ? read_bin_ff
                      : hbe_pkg::BIN_INDEX_W'(bin_addr);
   assign item_mode = mode_ff;
   assign bin_clamped = (mode_ff == hbe_pkg::MODE_ACCUMULATE) && (below_ff || hi_over);
   assign bin_hit = (mode_ff == hbe_pkg::MODE_ACCUMULATE) || (32'(read_bin_ff) < MAX_BINS);

endmodule

@@ design/hbe_count_store.sv @@
// Bin counter memory with a clearing pass after reset and the saturating update.
// Depends on hbe_pkg for the control bundle.
module hbe_count_store #(
   parameter int MAX_BINS = 256,
   parameter int COUNT_BITS = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  hbe_pkg::store_ctl_type      ctl,
   input  logic [$clog2(MAX_BINS)-1:0] addr,
   output logic [COUNT_BITS-1:0]       old_count,
   output logic [COUNT_BITS-1:0]       new_count,
   output logic                        busy
);

   localparam int ADDR_W = $clog2(MAX_BINS);

   logic [COUNT_BITS-1:0] mem [MAX_BINS];
   logic [COUNT_BITS-1:0] rd_data_ff;
   logic                  clr_active_ff;
   logic                  clr_active_in;
   logic [ADDR_W-1:0]     clr_ptr_ff;
   logic [ADDR_W-1:0]     clr_ptr_in;

   always_comb begin
      clr_active_in = clr_active_ff;
      clr_ptr_in = clr_ptr_ff;
      if (clr_active_ff) begin
         clr_ptr_in = clr_ptr_ff + ADDR_W'(1);
         if (clr_ptr_ff == ADDR_W'(MAX_BINS - 1)) begin
            clr_active_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_ptr_ff <= '0;
      end else begin
         clr_active_ff <= clr_active_in;
         clr_ptr_ff <= clr_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (clr_active_ff) begin
         mem[clr_ptr_ff] <= '0;
      end else if (ctl.wr_en) begin
         mem[addr] <= new_count;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   always_comb begin
      if (ctl.clear_op) begin
         new_count = '0;
      end else if (&rd_data_ff) begin
         new_count = rd_data_ff;
      end else begin
         new_count = rd_data_ff + COUNT_BITS'(1);
      end
   end

   assign old_count = rd_data_ff;
   assign busy = clr_active_ff;

endmodule

@@ design/histogram_binning_engine.sv @@
// Top level of the histogram binning engine: stream ports, registers and item sequencer.
// Depends on hbe_pkg, hbe_bin_calc and hbe_count_store.
//
//   Channel   Direction  Handshake              Payload
//   req_      in         req_tvalid/req_tready  tuser: mode; tdata: sample, read_bin
//   rsp_      out        rsp_tvalid/rsp_tready  tdata: bin_index, count; tuser: clamped
//   csr_      in         csr_valid/csr_ready    csr_index, csr_data
//
// Each item passes accept, multiply, counter read, then update and write back.
// One item is in progress at a time, each doing a single memory read-modify-write; a
// stalled rsp_ side holds the update state until the result register frees up.
// After reset a clearing pass zeroes all MAX_BINS counters with req_tready low.
module histogram_binning_engine #(
   parameter int MAX_BINS = 256,
   parameter int COUNT_BITS = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [hbe_pkg::REQ_TDATA_W-1:0]     req_tdata,  // sample, read_bin
   input  logic                                req_tuser,  // mode
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [hbe_pkg::RSP_TDATA_W-1:0]     rsp_tdata,  // bin_index, count
   output logic                                rsp_tuser,  // clamped
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [hbe_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [hbe_pkg::CSR_DATA_W-1:0]      csr_data
);

   localparam int ADDR_W = $clog2(MAX_BINS);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MUL = 2'd1;
   localparam logic [1:0] ST_READ = 2'd2;
   localparam logic [1:0] ST_UPDATE = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   logic [31:0] range_min_ff;
   logic [31:0] bins_per_unit_ff;
   logic [8:0]  bin_count_ff;

   logic                            rsp_valid_ff;
   logic                            rsp_valid_in;
   logic [hbe_pkg::RSP_TDATA_W-1:0] rsp_data_ff;
   logic [hbe_pkg::RSP_TDATA_W-1:0] rsp_data_in;
   logic                            rsp_user_ff;

   hbe_pkg::calc_ctl_type  calc_ctl;
   hbe_pkg::store_ctl_type store_ctl;

   logic                           item_mode;
   logic [ADDR_W-1:0]              bin_addr;
   logic [hbe_pkg::BIN_INDEX_W-1:0] bin_index;
   logic [ADDR_W-1:0]              last_bin;
   logic                           bin_clamped;
   logic                           bin_hit;
   logic [COUNT_BITS-1:0]          old_count;
   logic [COUNT_BITS-1:0]          new_count;
   logic                           store_busy;
   logic                           req_accept;
   logic                           out_free;
   logic [31:0]                    count_out;

   assign req_tready = (state_ff == ST_IDLE) && !store_busy;
   assign req_accept = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         range_min_ff <= hbe_pkg::RANGE_MIN_RESET;
         bins_per_unit_ff <= hbe_pkg::BINS_PER_UNIT_RESET;
         bin_count_ff <= hbe_pkg::BIN_COUNT_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            hbe_pkg::CSR_RANGE_MIN: range_min_ff <= csr_data;
            hbe_pkg::CSR_BINS_PER_UNIT: bins_per_unit_ff <= csr_data;
            hbe_pkg::CSR_BIN_COUNT: bin_count_ff <= csr_data[8:0];
            default: ;
         endcase
      end
   end

   hbe_bin_calc #(
      .MAX_BINS(MAX_BINS)
   ) u_calc (
      .clock(clock),
      .ctl(calc_ctl),
      .mode(req_tuser),
      .sample(req_tdata[31:0]),
      .read_bin(req_tdata[39:32]),
      .range_min(range_min_ff),
      .bins_per_unit(bins_per_unit_ff),
      .bin_count(bin_count_ff),
      .item_mode(item_mode),
      .bin_addr(bin_addr),
      .bin_index(bin_index),
      .last_bin(last_bin),
      .bin_clamped(bin_clamped),
      .bin_hit(bin_hit)
   );

   hbe_count_store #(
      .MAX_BINS(MAX_BINS),
      .COUNT_BITS(COUNT_BITS)
   ) u_store (
      .clock(clock),
      .reset(reset),
      .ctl(store_ctl),
      .addr(bin_addr),
      .old_count(old_count),
      .new_count(new_count),
      .busy(store_busy)
   );

   always_comb begin
      if (item_mode == hbe_pkg::MODE_ACCUMULATE) begin
         count_out = 32'(new_count);
      end else if (bin_hit) begin
         count_out = 32'(old_count);
      end else begin
         count_out = '0;
      end
   end

   always_comb begin
      state_in = state_ff;
      calc_ctl = '0;
      store_ctl = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;
      store_ctl.clear_op = (item_mode == hbe_pkg::MODE_READ_CLEAR);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               calc_ctl.load = 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            calc_ctl.mult = 1'b1;
            state_in = ST_READ;
         end
         ST_READ: begin
            store_ctl.rd_en = bin_hit;
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (out_free) begin
               store_ctl.wr_en = bin_hit;
               rsp_valid_in = 1'b1;
               rsp_data_in = {count_out, bin_index};
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == ST_UPDATE) && out_free) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= bin_clamped;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign rsp_tuser = rsp_user_ff;

   a_clear_no_result: assert property (@(posedge clock) disable iff (reset)
      store_busy |-> !rsp_tvalid)
      else $error("Result shown during the counter clearing pass.");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> !req_tready)
      else $error("Input accepted while an item is still in progress.");

   a_clamp_edge_bin: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |->
         (rsp_tdata[7:0] == 8'd0) || (rsp_tdata[7:0] == hbe_pkg::BIN_INDEX_W'(last_bin)))
      else $error("Clamped item landed in a bin other than the first or last.");

endmodule
